// ===== hdl/wsp_pkg.sv =====
// Shared types and constants for the WAVE stream parser.
`default_nettype none
package wsp_pkg;

  localparam int unsigned WSP_QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_SAMPLER = 2'd1;
  localparam logic [1:0] KIND_ACCEPT  = 2'd2;
  localparam logic [1:0] KIND_REJECT  = 2'd3;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_RF64 = 32'h52463634;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_DS64 = 32'h64733634;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [31:0] TAG_SMPL = 32'h736D706C;

  localparam logic [15:0] FMT_PCM        = 16'h0001;
  localparam logic [15:0] FMT_FLOAT      = 16'h0003;
  localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               last_of_run;
    logic [31:0]        sample_value;
    logic [15:0]        channel_count;
    logic [30:0]        sample_rate;
    logic [15:0]        bits_per_sample;
    logic               float_format;
    logic signed [31:0] unity_note;
    logic [6:0]         pitch_cents;
    logic signed [31:0] loop_first_frame;
    logic signed [31:0] loop_last_frame;
    logic               loop_present;
  } out_t;

  // Work handed from the parser to the converter: up to two results per byte.
  typedef struct packed {
    logic        has_first;
    logic        first_smpl;
    logic [63:0] assembly;
    logic [15:0] bits;
    logic        flt;
    logic [31:0] root;
    logic [31:0] frac;
    logic [31:0] lstart;
    logic [31:0] lend;
    logic        lpres;
    logic        has_final;
    logic        final_ok;
    logic [15:0] chan;
    logic [30:0] rate;
  } job_t;

endpackage
`default_nettype wire

// ===== hdl/wsp_front.sv =====
// Byte parser: walks header and chunks, captures fields, issues jobs.
`default_nettype none
module wsp_front (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  input  wsp_pkg::in_t    in_data_i,
  input  wire             full_i,
  output logic            push_o,
  output wsp_pkg::job_t   job_o
);
  import wsp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEAD, PH_CHDR, PH_BODY_EVEN, PH_BODY_ODD, PH_PAD, PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [5:0]  pos_q, pos_d;
  logic [31:0] tag_q, tag_d;
  logic [63:0] rem_q, rem_d;
  logic [5:0]  off_q, off_d;
  logic [63:0] ext_q, ext_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic        flt_q, flt_d;
  logic        data_q, data_d;
  logic        rej_q, rej_d;
  logic        valid_q, valid_d;
  logic [63:0] asm_q, asm_d;
  logic [12:0] sidx_q, sidx_d;
  logic [31:0] sw_q [5];
  logic [31:0] sw_d [5];

  logic        acc, eof, ended, go, ok;
  logic [7:0]  b;
  logic [5:0]  pos_inc, off_inc;
  logic [12:0] sidx_n;
  job_t        job;

  assign acc = in_valid_i && !full_i;
  assign b   = in_data_i.file_byte;
  assign eof = in_data_i.end_of_file;

  always_comb begin
    phase_d = phase_q; pos_d = pos_q; tag_d = tag_q; rem_d = rem_q; off_d = off_q;
    ext_d = ext_q; fmt_d = fmt_q; ch_d = ch_q; rate_d = rate_q; bits_d = bits_q;
    flt_d = flt_q; data_d = data_q; rej_d = rej_q; valid_d = valid_q; asm_d = asm_q;
    sidx_d = sidx_q;
    for (int i = 0; i < 5; i++) sw_d[i] = sw_q[i];
    job = '0;
    ended = 1'b0; go = 1'b0; ok = 1'b0;
    sidx_n = sidx_q + 13'd1;
    pos_inc = (pos_q == 6'd63) ? pos_q : pos_q + 6'd1;
    off_inc = (off_q == 6'd63) ? off_q : off_q + 6'd1;
    if (acc) begin
      unique case (phase_q)
        PH_HEAD: begin
          tag_d = {tag_q[23:0], b};
          if (pos_q == 6'd3 && tag_d != TAG_RIFF && tag_d != TAG_RF64) begin
            rej_d = 1'b1; phase_d = PH_DONE;
          end else if (pos_q == 6'd11) begin
            if (tag_d != TAG_WAVE) begin
              rej_d = 1'b1; phase_d = PH_DONE;
            end else begin
              phase_d = PH_CHDR; off_d = '0;
            end
          end
        end
        PH_CHDR: begin
          if (!off_q[2]) tag_d = {tag_q[23:0], b};
          else if (off_q[1:0] == 2'd0) rem_d = {56'b0, b};
          else rem_d = rem_q | ({56'b0, b} << {off_q[1:0], 3'b000});
          off_d = off_q + 6'd1;
          if (off_q[2:0] == 3'd7) begin
            off_d = '0; sidx_d = '0; asm_d = '0; go = 1'b1;
            if (tag_q == TAG_FMT) begin
              valid_d = 1'b0;
              if (data_q || rem_d == 64'd0) begin
                rej_d = 1'b1; phase_d = PH_DONE; go = 1'b0;
              end
            end else if (tag_q == TAG_DATA) begin
              if (!valid_q || data_q || bits_q[15:3] == 13'd0) begin
                rej_d = 1'b1; phase_d = PH_DONE; go = 1'b0;
              end else if (rem_d == 64'h0000_0000_FFFF_FFFF && ext_q != 64'd0) begin
                rem_d = ext_q;
              end
            end
            if (go) begin
              if (rem_d == 64'd0) phase_d = PH_DONE;
              else if (rem_d[0]) phase_d = PH_BODY_ODD;
              else phase_d = PH_BODY_EVEN;
            end
          end
        end
        PH_BODY_EVEN, PH_BODY_ODD: begin
          if (tag_q == TAG_FMT) begin
            if (off_q < 6'd2) fmt_d[{off_q[0], 3'b000} +: 8] = b;
            else if (off_q < 6'd4) ch_d[{off_q[0], 3'b000} +: 8] = b;
            else if (off_q < 6'd8) rate_d[{off_q[1:0], 3'b000} +: 8] = b;
            else if (off_q == 6'd14 || off_q == 6'd15) bits_d[{off_q[0], 3'b000} +: 8] = b;
            else if ((off_q == 6'd24 || off_q == 6'd25) && fmt_q == FMT_EXTENSIBLE
                     && (rem_q + {58'b0, off_q}) >= 64'd40) begin
              if (off_q == 6'd24) asm_d = {56'b0, b};
              else fmt_d = {b, asm_q[7:0]};
            end
          end else if (tag_q == TAG_DS64) begin
            if (off_q >= 6'd8 && off_q < 6'd16) ext_d[{off_q[2:0], 3'b000} +: 8] = b;
          end else if (tag_q == TAG_SMPL) begin
            if (off_q >= 6'd12 && off_q < 6'd16) sw_d[0][{off_q[1:0], 3'b000} +: 8] = b;
            else if (off_q >= 6'd16 && off_q < 6'd20) sw_d[1][{off_q[1:0], 3'b000} +: 8] = b;
            else if (off_q >= 6'd28 && off_q < 6'd32) sw_d[2][{off_q[1:0], 3'b000} +: 8] = b;
            else if (off_q >= 6'd44 && off_q < 6'd48) sw_d[3][{off_q[1:0], 3'b000} +: 8] = b;
            else if (off_q >= 6'd48 && off_q < 6'd52) sw_d[4][{off_q[1:0], 3'b000} +: 8] = b;
          end else if (tag_q == TAG_DATA) begin
            data_d = 1'b1;
            if (sidx_q < 13'd8) asm_d = asm_q | ({56'b0, b} << {sidx_q[2:0], 3'b000});
            if (sidx_n == bits_q[15:3]) begin
              job.has_first = 1'b1;
              job.assembly  = asm_d;
              sidx_d = '0; asm_d = '0;
            end else begin
              sidx_d = sidx_n;
            end
          end
          rem_d = rem_q - 64'd1;
          off_d = off_inc;
          ended = (rem_d == 64'd0);
          if (ended) begin
            phase_d = (phase_q == PH_BODY_ODD) ? PH_PAD : PH_CHDR;
            if (tag_q == TAG_FMT) begin
              if (off_inc < 6'd16) begin
                rej_d = 1'b1; phase_d = PH_DONE;
              end else begin
                flt_d = (fmt_d == FMT_FLOAT);
                if (fmt_d != FMT_PCM && fmt_d != FMT_FLOAT && fmt_d != FMT_EXTENSIBLE) begin
                  rej_d = 1'b1; phase_d = PH_DONE;
                end else begin
                  valid_d = 1'b1;
                end
              end
            end
          end
          // Sampler info at body end, or at end of file inside the body.
          if (tag_q == TAG_SMPL && off_inc >= 6'd36 && (ended || eof)) begin
            job.has_first  = 1'b1;
            job.first_smpl = 1'b1;
            job.root = sw_d[0];
            job.frac = sw_d[1];
            if (sw_d[2] != 32'd0 && off_inc >= 6'd60) begin
              job.lstart = sw_d[3];
              job.lend   = sw_d[4];
              job.lpres  = 1'b1;
            end
          end
          if (ended && phase_d != PH_DONE) off_d = '0;
        end
        PH_PAD: begin
          phase_d = PH_CHDR; off_d = '0;
        end
        default: ;
      endcase
      pos_d = pos_inc;
      job.bits = bits_d;
      job.flt  = flt_d;
      if (eof) begin
        ok = !rej_d && pos_inc >= 6'd44 && data_d && valid_d && ch_d != 16'd0
             && rate_d != 32'd0 && !rate_d[31] && bits_d[15:3] != 13'd0;
        job.has_final = 1'b1;
        job.final_ok  = ok;
        job.chan      = ch_d;
        job.rate      = rate_d[30:0];
        // Return to the reset state for the next file.
        phase_d = PH_HEAD; pos_d = '0; tag_d = '0; rem_d = '0; off_d = '0; ext_d = '0;
        fmt_d = '0; ch_d = '0; rate_d = '0; bits_d = 16'd16; flt_d = 1'b0;
        data_d = 1'b0; rej_d = 1'b0; valid_d = 1'b0; asm_d = '0; sidx_d = '0;
        for (int i = 0; i < 5; i++) sw_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD; pos_q <= '0; tag_q <= '0; rem_q <= '0; off_q <= '0;
      ext_q <= '0; fmt_q <= '0; ch_q <= '0; rate_q <= '0; bits_q <= 16'd16;
      flt_q <= 1'b0; data_q <= 1'b0; rej_q <= 1'b0; valid_q <= 1'b0;
      asm_q <= '0; sidx_q <= '0;
      for (int i = 0; i < 5; i++) sw_q[i] <= '0;
    end else begin
      phase_q <= phase_d; pos_q <= pos_d; tag_q <= tag_d; rem_q <= rem_d; off_q <= off_d;
      ext_q <= ext_d; fmt_q <= fmt_d; ch_q <= ch_d; rate_q <= rate_d; bits_q <= bits_d;
      flt_q <= flt_d; data_q <= data_d; rej_q <= rej_d; valid_q <= valid_d;
      asm_q <= asm_d; sidx_q <= sidx_d;
      for (int i = 0; i < 5; i++) sw_q[i] <= sw_d[i];
    end
  end

  assign push_o = acc && (job.has_first || job.has_final);
  assign job_o  = job;

endmodule
`default_nettype wire

// ===== hdl/wsp_queue.sv =====
// Job queue between parser and converter.
`default_nettype none
module wsp_queue #(
  parameter int unsigned Depth = wsp_pkg::WSP_QUEUE_DEPTH
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  wsp_pkg::job_t  push_data_i,
  input  wire            pop_i,
  output logic           full_o,
  output logic           empty_o,
  output wsp_pkg::job_t  head_o
);
  import wsp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      if (do_pop) rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (!do_push && do_pop) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/wsp_back.sv =====
// Converter: sample to single in two stages, then the result register.
`default_nettype none
module wsp_back (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            empty_i,
  input  wsp_pkg::job_t  head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output wsp_pkg::out_t  out_data_o
);
  import wsp_pkg::*;

  typedef enum logic [1:0] {CV_ZERO, CV_PASS, CV_INT, CV_F64} conv_e;

  function automatic logic [63:0] rne(input logic [63:0] m, input logic [5:0] sh);
    logic [63:0] q, rem, half;
    q    = m >> sh;
    rem  = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 6'd1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // Stage 1: classify, magnitude, leading one, cents.
  logic               s1_v_q;
  job_t               s1_job_q;
  conv_e              s1_cv_q, cv;
  logic               s1_sign_q, sgn;
  logic [31:0]        s1_mag_q, mag;
  logic [4:0]         s1_p_q, p;
  logic [4:0]         s1_frac_q, frac;
  logic [6:0]         s1_cents_q, cents;
  logic signed [32:0] v, vabs;
  logic [39:0]        csum;

  always_comb begin
    cv = CV_ZERO; frac = 5'd0; v = '0;
    if (head_i.flt) begin
      if (head_i.bits == 16'd32) cv = CV_PASS;
      else if (head_i.bits == 16'd64) cv = CV_F64;
    end else begin
      case (head_i.bits)
        16'd8: begin
          v = $signed({25'b0, head_i.assembly[7:0]}) - 33'sd128; frac = 5'd7; cv = CV_INT;
        end
        16'd16: begin
          v = $signed({{17{head_i.assembly[15]}}, head_i.assembly[15:0]});
          frac = 5'd15; cv = CV_INT;
        end
        16'd24: begin
          v = $signed({{9{head_i.assembly[23]}}, head_i.assembly[23:0]});
          frac = 5'd23; cv = CV_INT;
        end
        16'd32: begin
          v = $signed({head_i.assembly[31], head_i.assembly[31:0]});
          frac = 5'd31; cv = CV_INT;
        end
        default: cv = CV_ZERO;
      endcase
    end
    sgn  = v[32];
    vabs = sgn ? -v : v;
    mag  = vabs[31:0];
    if (cv == CV_INT && mag == 32'd0) cv = CV_ZERO;
    p = 5'd0;
    for (int i = 0; i < 32; i++) if (mag[i]) p = 5'(i);
    csum  = {8'b0, head_i.frac} * 40'd100 + 40'h0080000000;
    cents = csum[38:32];
  end

  // Stage 2: rounding and packing.
  logic [31:0]        val;
  logic [8:0]         exp_m1;
  logic [31:0]        sig;
  logic [10:0]        de;
  logic [51:0]        man;
  logic [63:0]        m53;
  logic signed [12:0] fe, shs;
  logic [31:0]        r;
  logic [31:0]        sbit;

  always_comb begin
    val = 32'd0; sig = 32'd0; r = 32'd0;
    exp_m1 = {4'b0, s1_p_q} + 9'd126 - {4'b0, s1_frac_q};
    de   = s1_job_q.assembly[62:52];
    man  = s1_job_q.assembly[51:0];
    m53  = {11'b0, 1'b1, man};
    fe   = $signed({2'b0, de}) - 13'sd896;
    shs  = 13'sd30 - fe;
    sbit = {s1_job_q.assembly[63], 31'b0};
    case (s1_cv_q)
      CV_PASS: val = s1_job_q.assembly[31:0];
      CV_INT: begin
        if (s1_p_q <= 5'd23) sig = s1_mag_q << (5'd23 - s1_p_q);
        else sig = 32'(rne({32'b0, s1_mag_q}, 6'(s1_p_q - 5'd23)));
        val = {s1_sign_q, 31'b0} | ({exp_m1[7:0], 23'b0} + sig);
      end
      CV_F64: begin
        if (de == 11'h7FF) begin
          val = sbit | 32'h7F800000 | ((man != 52'd0) ? (32'h00400000 | {9'b0, man[51:29]})
                                                       : 32'd0);
        end else if (de == 11'd0) begin
          val = sbit;
        end else if (fe >= 13'sd255) begin
          val = sbit | 32'h7F800000;
        end else if (fe >= 13'sd1) begin
          r = {fe[7:0] - 8'd1, 23'b0} + 32'(rne(m53, 6'd29));
          if (r > 32'h7F800000) r = 32'h7F800000;
          val = sbit | r;
        end else if (shs > 13'sd54) begin
          val = sbit;
        end else begin
          val = sbit | 32'(rne(m53, shs[5:0]));
        end
      end
      default: val = 32'd0;
    endcase
  end

  // Result register: one or two transfers per job.
  logic        out_v_q, second_q;
  job_t        out_job_q;
  logic [31:0] out_val_q;
  logic [6:0]  out_cents_q;
  logic        out_last, xfer, out_free, s1_free;
  out_t        od;

  assign out_last = second_q || !out_job_q.has_first || !out_job_q.has_final;
  assign xfer     = out_v_q && !out_stall_i;
  assign out_free = !out_v_q || (xfer && out_last);
  assign s1_free  = !s1_v_q || out_free;
  assign pop_o    = !empty_i && s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; out_v_q <= 1'b0; second_q <= 1'b0;
    end else begin
      if (s1_free) s1_v_q <= !empty_i;
      if (out_free) begin
        out_v_q  <= s1_v_q;
        second_q <= 1'b0;
      end else if (xfer) begin
        second_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_job_q <= head_i; s1_cv_q <= cv; s1_sign_q <= sgn; s1_mag_q <= mag;
      s1_p_q <= p; s1_frac_q <= frac; s1_cents_q <= cents;
    end
    if (out_free) begin
      out_job_q <= s1_job_q; out_val_q <= val; out_cents_q <= s1_cents_q;
    end
  end

  always_comb begin
    od = '0;
    od.last_of_run = out_last;
    if (!second_q && out_job_q.has_first) begin
      if (out_job_q.first_smpl) begin
        od.kind         = KIND_SAMPLER;
        od.unity_note   = out_job_q.root;
        od.pitch_cents  = out_cents_q;
        od.loop_present = out_job_q.lpres;
        if (out_job_q.lpres) begin
          od.loop_first_frame = out_job_q.lstart;
          od.loop_last_frame  = out_job_q.lend;
        end
      end else begin
        od.kind            = KIND_SAMPLE;
        od.sample_value    = out_val_q;
        od.bits_per_sample = out_job_q.bits;
        od.float_format    = out_job_q.flt;
      end
    end else if (out_job_q.final_ok) begin
      od.kind            = KIND_ACCEPT;
      od.channel_count   = out_job_q.chan;
      od.sample_rate     = out_job_q.rate;
      od.bits_per_sample = out_job_q.bits;
      od.float_format    = out_job_q.flt;
    end else begin
      od.kind = KIND_REJECT;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = od;

endmodule
`default_nettype wire

// ===== hdl/wav_stream_parser_core.sv =====
// Top level of the WAVE stream parser.
// Input channel: one file byte per transfer, with end_of_file on the last byte.
// The parser takes one byte per cycle while its job queue has room; bytes that
// cause no result leave nothing behind them.
// Output channel: samples as IEEE singles, sampler info, and a final accept or
// reject per file; last_of_run marks the last result caused by a byte.
// Path: a byte is parsed and its job written to the queue at the accepting edge,
// then the job passes the conversion stage and the result register. A byte with
// two results (a last sample or sampler info together with the verdict) holds
// the result register for both; otherwise one result per cycle is sustained without stalls.
// When the receiver stalls, the result holds, the conversion stage and queue
// fill, and then the input stalls. After the end_of_file byte the parser is
// back in its reset state, so the next byte opens a new file.
// Reset clears the parser, empties the queue and drops pending results.
`default_nettype none
module wav_stream_parser_core #(
  parameter int unsigned QueueDepth = wsp_pkg::WSP_QUEUE_DEPTH
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  wsp_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output wsp_pkg::out_t  out_data_o
);
  import wsp_pkg::*;

  logic push, pop, full, empty;
  job_t job, head;

  assign in_stall_o = full;

  wsp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_data_i,
    .full_i(full), .push_o(push), .job_o(job)
  );

  wsp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(job), .pop_i(pop),
    .full_o(full), .empty_o(empty), .head_o(head)
  );

  wsp_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
`default_nettype wire

// ===== hdl/wsp_checker.sv =====
// Port checks for the WAVE stream parser, bound to the top level.
`default_nettype none
module wsp_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            out_valid_o,
  input wire            out_stall_i,
  input wsp_pkg::out_t  out_data_o
);
  import wsp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_ACCEPT || out_data_o.kind == KIND_REJECT)
    |-> out_data_o.last_of_run)
    else $error("verdict not last of run");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_REJECT
    |-> out_data_o.sample_value == 32'd0 && out_data_o.channel_count == 16'd0
        && out_data_o.bits_per_sample == 16'd0 && out_data_o.loop_present == 1'b0)
    else $error("reject carries fields");

  a_noloop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_SAMPLER && !out_data_o.loop_present
    |-> out_data_o.loop_first_frame == 32'sd0 && out_data_o.loop_last_frame == 32'sd0)
    else $error("loop fields without loop");

endmodule

bind wav_stream_parser_core wsp_checker u_wsp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i), .out_data_o(out_data_o)
);
`default_nettype wire
